/* sv/tsc_pkg.sv */
// Shared types, codes and a helper function of the Thumb-subset core.
package tsc_pkg;

	// Instruction groups, taken from bits 15:12 of the halfword.
	localparam logic [3:0] GRP_MOV_REG = 4'h0;
	localparam logic [3:0] GRP_ADD_REG = 4'h1;
	localparam logic [3:0] GRP_MOV_IMM = 4'h2;
	localparam logic [3:0] GRP_ADD_IMM = 4'h3;
	localparam logic [3:0] GRP_LDST_SP = 4'h9;
	localparam logic [3:0] GRP_BCC     = 4'hD;
	localparam logic [3:0] GRP_B       = 4'hE;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SELF    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_STACK_BASE    = 1'b0;
	localparam logic CFG_START_ADDRESS = 1'b1;

	localparam logic [31:0] STACK_BASE_RESET = 32'h2000_0000;
	localparam logic [31:0] START_ADDR_RESET = 32'h0000_0000;

	// An unconditional branch with this offset field targets its own address.
	localparam logic [10:0] B_SELF_OFFSET = 11'h7FE;

	typedef enum logic [3:0] {
		CLS_MOV_REG,
		CLS_ADD_REG,
		CLS_MOV_IMM,
		CLS_ADD_IMM,
		CLS_LDR,
		CLS_STR,
		CLS_BCC,
		CLS_B,
		CLS_SELF_LOOP,
		CLS_ILLEGAL
	} op_class_t;

	// One decoded instruction as it waits between the front and the back.
	typedef struct packed {
		op_class_t   cls;
		logic [2:0]  rd;
		logic [2:0]  rn;
		logic [2:0]  rm;
		logic [7:0]  imm8;
		logic        sub;
		logic [3:0]  cond;
		logic [31:0] boff;
		logic [31:0] maddr;
	} dec_op_t;

	function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] fl);
		logic n, z, c, v, r;
		n = fl[3];
		z = fl[2];
		c = fl[1];
		v = fl[0];
		unique case (cc)
			4'h0: r = z;
			4'h1: r = !z;
			4'h2: r = c;
			4'h3: r = !c;
			4'h4: r = n;
			4'h5: r = !n;
			4'h6: r = v;
			4'h7: r = !v;
			4'h8: r = c && !z;
			4'h9: r = !c || z;
			4'hA: r = (n == v);
			4'hB: r = (n != v);
			4'hC: r = !z && (n == v);
			4'hD: r = z || (n != v);
			4'hE: r = 1'b1;
			4'hF: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* sv/tsc_front.sv */
// Front end: accepts instruction beats, decodes them and queues them for the back end.
module tsc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [15:0]      instruction,
	input  logic             cfg_valid,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             busy,
	output logic             head_valid,
	output tsc_pkg::dec_op_t head_op,
	input  logic             head_pop
);
	import tsc_pkg::*;

	logic [31:0] stack_base_q;
	logic        halted_q;
	dec_op_t     fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	dec_op_t     dec;
	logic        accept, push, halts;

	assign in_stall   = busy || (count_q == 2'd2);
	assign accept     = in_valid && !in_stall;
	assign push       = accept && !halted_q;
	assign head_valid = (count_q != 2'd0);
	assign head_op    = fifo_q[rd_ptr_q];

	always_comb begin
		dec       = '0;
		dec.imm8  = instruction[7:0];
		dec.sub   = 1'b0;
		dec.cond  = instruction[11:8];
		dec.maddr = stack_base_q + {22'd0, instruction[7:0], 2'b00};
		dec.rd    = instruction[10:8];
		dec.rn    = instruction[10:8];
		dec.rm    = instruction[8:6];
		dec.boff  = {{23{instruction[7]}}, instruction[7:0], 1'b0};
		halts     = 1'b0;
		unique case (instruction[15:12])
			GRP_MOV_REG: begin
				dec.cls = CLS_MOV_REG;
				dec.rd  = instruction[2:0];
				dec.rn  = instruction[5:3];
			end
			GRP_ADD_REG: begin
				dec.cls = CLS_ADD_REG;
				dec.rd  = instruction[2:0];
				dec.rn  = instruction[5:3];
				dec.sub = instruction[9];
			end
			GRP_MOV_IMM: dec.cls = CLS_MOV_IMM;
			GRP_ADD_IMM: begin
				dec.cls = CLS_ADD_IMM;
				dec.sub = instruction[11];
			end
			GRP_LDST_SP: dec.cls = instruction[11] ? CLS_LDR : CLS_STR;
			GRP_BCC:     dec.cls = CLS_BCC;
			GRP_B: begin
				dec.boff = {{20{instruction[10]}}, instruction[10:0], 1'b0};
				if (instruction[10:0] == B_SELF_OFFSET) begin
					dec.cls = CLS_SELF_LOOP;
					halts   = 1'b1;
				end else begin
					dec.cls = CLS_B;
				end
			end
			default: begin
				dec.cls = CLS_ILLEGAL;
				halts   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_base_q <= STACK_BASE_RESET;
			halted_q     <= 1'b0;
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			count_q      <= 2'd0;
		end else begin
			if (cfg_valid && cfg_index == CFG_STACK_BASE) begin
				stack_base_q <= cfg_data;
			end
			if (push && halts) begin
				halted_q <= 1'b1;
			end
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (head_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, head_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

endmodule

/* sv/tsc_back.sv */
// Back end: register file, flags, program counter, data RAM and the result register.
module tsc_back #(
	parameter int RAM_WORDS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data,
	output logic             busy,
	input  logic             head_valid,
	input  tsc_pkg::dec_op_t head_op,
	output logic             head_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      executed_pc,
	output logic [31:0]      next_pc,
	output logic [1:0]       status,
	output logic             branch_taken,
	output logic             dest_valid,
	output logic [2:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             store_valid,
	output logic [31:0]      mem_address,
	output logic [3:0]       flags_out
);
	import tsc_pkg::*;

	localparam int AW = $clog2(RAM_WORDS);

	logic [31:0] rf_q [8];
	logic [31:0] pc_q;
	logic [3:0]  flags_q;
	logic [31:0] ram_q [RAM_WORDS];
	logic [31:0] rdata_q;
	logic        clr_q;
	logic [AW-1:0] clr_cnt_q;

	logic        s2_valid_q, s2_load_q;
	logic [31:0] s2_pc_q, s2_next_q, s2_dval_q, s2_maddr_q;
	logic [1:0]  s2_status_q;
	logic        s2_taken_q, s2_dvalid_q, s2_svalid_q;
	logic [2:0]  s2_didx_q;
	logic [3:0]  s2_flags_q;

	logic        fire, s2_leave, fwd;
	logic [31:0] ra, rb, rs, opb, res, nxt, maddr;
	logic [32:0] sum;
	logic [3:0]  nflags;
	logic [1:0]  st;
	logic        taken, dvalid, svalid, is_load, wr_res, ovf;
	logic [AW-1:0] ram_idx;

	assign busy     = clr_q;
	assign s2_leave = s2_valid_q && !out_stall;
	assign fire     = head_valid && !clr_q && (!s2_valid_q || !out_stall);
	assign head_pop = fire;
	assign fwd      = s2_valid_q && s2_load_q;
	assign ram_idx  = head_op.maddr[AW+1:2];

	// Operand reads, with the pending load value bypassed in.
	always_comb begin
		ra = (fwd && s2_didx_q == head_op.rn) ? rdata_q : rf_q[head_op.rn];
		rb = (fwd && s2_didx_q == head_op.rm) ? rdata_q : rf_q[head_op.rm];
		rs = (fwd && s2_didx_q == head_op.rd) ? rdata_q : rf_q[head_op.rd];
	end

	always_comb begin
		opb    = (head_op.cls == CLS_ADD_REG) ? rb : {24'd0, head_op.imm8};
		sum    = head_op.sub ? ({1'b0, ra} + {1'b0, ~opb} + 33'd1)
		                     : ({1'b0, ra} + {1'b0, opb});
		ovf    = head_op.sub ? ((ra[31] ^ opb[31]) & (ra[31] ^ sum[31]))
		                     : (~(ra[31] ^ opb[31]) & (ra[31] ^ sum[31]));
		res     = 32'd0;
		nflags  = flags_q;
		nxt     = pc_q + 32'd2;
		st      = ST_OK;
		taken   = 1'b0;
		dvalid  = 1'b0;
		svalid  = 1'b0;
		is_load = 1'b0;
		wr_res  = 1'b0;
		maddr   = 32'd0;
		unique case (head_op.cls)
			CLS_MOV_REG, CLS_MOV_IMM: begin
				res       = (head_op.cls == CLS_MOV_REG) ? ra : {24'd0, head_op.imm8};
				nflags[3] = res[31];
				nflags[2] = (res == 32'd0);
				dvalid    = 1'b1;
				wr_res    = 1'b1;
			end
			CLS_ADD_REG, CLS_ADD_IMM: begin
				res    = sum[31:0];
				nflags = {sum[31], sum[31:0] == 32'd0, sum[32], ovf};
				dvalid = 1'b1;
				wr_res = 1'b1;
			end
			CLS_LDR: begin
				maddr   = head_op.maddr;
				dvalid  = 1'b1;
				is_load = 1'b1;
			end
			CLS_STR: begin
				maddr  = head_op.maddr;
				svalid = 1'b1;
			end
			CLS_BCC: begin
				if (cond_holds(head_op.cond, flags_q)) begin
					nxt   = pc_q + 32'd4 + head_op.boff;
					taken = 1'b1;
				end
			end
			CLS_B: begin
				nxt   = pc_q + 32'd4 + head_op.boff;
				taken = 1'b1;
			end
			CLS_SELF_LOOP: begin
				nxt = pc_q;
				st  = ST_SELF;
			end
			CLS_ILLEGAL: begin
				nxt = pc_q;
				st  = ST_ILLEGAL;
			end
			default: begin
				nxt = pc_q;
				st  = ST_ILLEGAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= 32'd0;
			end
			pc_q       <= START_ADDR_RESET;
			flags_q    <= 4'd0;
			s2_valid_q <= 1'b0;
			clr_q      <= 1'b1;
			clr_cnt_q  <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(RAM_WORDS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			// A load retires into the register file as its beat leaves;
			// a younger write in the same cycle wins.
			if (s2_leave && s2_load_q) begin
				rf_q[s2_didx_q] <= rdata_q;
			end
			if (fire && wr_res) begin
				rf_q[head_op.rd] <= res;
			end
			if (fire) begin
				flags_q <= nflags;
			end
			if (cfg_valid && cfg_index == CFG_START_ADDRESS) begin
				pc_q <= cfg_data;
			end else if (fire) begin
				pc_q <= nxt;
			end
			if (fire) begin
				s2_valid_q <= 1'b1;
			end else if (s2_leave) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			s2_pc_q     <= pc_q;
			s2_next_q   <= nxt;
			s2_status_q <= st;
			s2_taken_q  <= taken;
			s2_dvalid_q <= dvalid;
			s2_didx_q   <= dvalid ? head_op.rd : 3'd0;
			s2_dval_q   <= res;
			s2_load_q   <= is_load;
			s2_svalid_q <= svalid;
			s2_maddr_q  <= maddr;
			s2_flags_q  <= nflags;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			ram_q[clr_cnt_q] <= 32'd0;
		end else if (fire && svalid) begin
			ram_q[ram_idx] <= rs;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_load) begin
			rdata_q <= ram_q[ram_idx];
		end
	end

	assign out_valid    = s2_valid_q;
	assign executed_pc  = s2_pc_q;
	assign next_pc      = s2_next_q;
	assign status       = s2_status_q;
	assign branch_taken = s2_taken_q;
	assign dest_valid   = s2_dvalid_q;
	assign dest_index   = s2_didx_q;
	assign dest_value   = s2_load_q ? rdata_q : s2_dval_q;
	assign store_valid  = s2_svalid_q;
	assign mem_address  = s2_maddr_q;
	assign flags_out    = s2_flags_q;

endmodule

/* sv/thumb_subset_cpu_core_top.sv */
// Top level of the Thumb-subset core: front end, decoded-instruction queue and back end.
// An accepted instruction beat is queued, then executes from the queue head into the result register.
// Throughput: one instruction per cycle unless stalled, set by the back end's single execute step.
// Reset: arst_n clears registers, flags and the halt mark and loads the reset PC; the data
// RAM is then cleared one word a cycle, with in_stall held high until the last word is cleared.
// Configuration writes are taken in every cycle, including during that clearing pass.
module thumb_subset_cpu_core_top #(
	parameter int RAM_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] instruction,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] executed_pc,
	output logic [31:0] next_pc,
	output logic [1:0]  status,
	output logic        branch_taken,
	output logic        dest_valid,
	output logic [2:0]  dest_index,
	output logic [31:0] dest_value,
	output logic        store_valid,
	output logic [31:0] mem_address,
	output logic [3:0]  flags_out
);
	import tsc_pkg::*;

	logic    busy;
	logic    head_valid, head_pop;
	dec_op_t head_op;
	logic    cfg_we;

	// The configuration registers are plain flops, so every write beat lands at once.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// The front end decodes each beat, resolves halting instructions on its own
	// (a self loop and an unknown group are known from the halfword alone) and
	// drops every beat after one of them.
	tsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.instruction (instruction),
		.cfg_valid   (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.busy        (busy),
		.head_valid  (head_valid),
		.head_op     (head_op),
		.head_pop    (head_pop)
	);

	// The back end executes one queued instruction per cycle when not stalled. A load
	// reads the RAM into a registered data word, which is bypassed to the next instruction's
	// operands and written into the register file as the result beat leaves.
	tsc_back #(
		.RAM_WORDS (RAM_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.busy         (busy),
		.head_valid   (head_valid),
		.head_op      (head_op),
		.head_pop     (head_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.executed_pc  (executed_pc),
		.next_pc      (next_pc),
		.status       (status),
		.branch_taken (branch_taken),
		.dest_valid   (dest_valid),
		.dest_index   (dest_index),
		.dest_value   (dest_value),
		.store_valid  (store_valid),
		.mem_address  (mem_address),
		.flags_out    (flags_out)
	);

endmodule
